>>> rtl/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define DDO_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a trigger in one cycle is followed by a condition in the next.
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ddo_pkg.sv
// Shared types, constants and tables of the wheel odometry block.
package ddo_pkg;

  // Defaults for the top-level parameters.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 32;

  // Configuration register indexes and reset values.
  localparam logic [0:0]  REG_STRAIGHT   = 1'b0;
  localparam logic [0:0]  REG_TURN       = 1'b1;
  localparam logic [31:0] STRAIGHT_RESET = 32'h0100_0000;
  localparam logic [31:0] TURN_RESET     = 32'h0001_0000;

  // Distance is product / 512000, done as a shift by 12 and a divide by 125.
  localparam int          DIST_SHIFT = 12;
  localparam logic [7:0]  DIST_DIV   = 8'd125;
  localparam logic [64:0] DIST_BIAS  = 65'd256000;
  localparam int          DIV_W      = 65 - DIST_SHIFT;
  localparam int          DIST_W     = 46;
  localparam logic [31:0] MS_PER_S   = 32'd1000;

  // Reciprocal of 125 for a 15-bit partial dividend: ceil(2^22 / 125).
  localparam logic [15:0] DIST_RECIP    = 16'd33555;
  localparam int          DIST_RECIP_SH = 22;

  // CORDIC start gain and arctangent table, binary angle units.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
    30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
    30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051, 30'h00000028,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001,
    30'h00000000, 30'h00000000
  };

  // One classified report as it waits between front and back.
  typedef struct packed {
    logic              sum_neg;
    logic [32:0]       sum_mag;
    logic              dif_neg;
    logic [32:0]       dif_mag;
    logic signed [7:0] interval;
    logic              interval_zero;
  } ddo_item_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [7:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Status of the back end.
  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

>>> rtl/ddo_req_if.sv
// Input channel carrying one sensor report per transaction.
interface ddo_req_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic signed [7:0]  interval_ms;

  modport source (output valid, left_count, right_count, interval_ms, input ready);
  modport sink (input valid, left_count, right_count, interval_ms, output ready);
endinterface

>>> rtl/ddo_res_if.sv
// Output channel carrying one pose and velocity result per transaction.
interface ddo_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] lin_vel;
  logic signed [31:0] ang_vel;
  logic               interval_zero;

  modport source (output valid, pos_x, pos_y, heading, lin_vel, ang_vel, interval_zero,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading, lin_vel, ang_vel, interval_zero,
                output ready);
endinterface

>>> rtl/ddo_cfg_if.sv
// Configuration write channel: register index and write data.
interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ddo_front.sv
// Front end: takes reports, forms wrapped count deltas and classifies them.
module ddo_front #(
  parameter int COUNT_BITS = ddo_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ddo_req_if.sink           req,
  output ddo_pkg::ddo_item_t item,
  output logic              push,
  input  logic              full
);
  import ddo_pkg::*;

  logic [COUNT_BITS-1:0]        prev_left;
  logic [COUNT_BITS-1:0]        prev_right;
  logic signed [COUNT_BITS-1:0] dl;
  logic signed [COUNT_BITS-1:0] dr;
  logic signed [COUNT_BITS:0]   sum;
  logic signed [COUNT_BITS:0]   dif;
  logic [COUNT_BITS:0]          sum_abs;
  logic [COUNT_BITS:0]          dif_abs;

  // Deltas wrap to the counter width.
  assign dl = $signed(req.left_count[COUNT_BITS-1:0] - prev_left);
  assign dr = $signed(req.right_count[COUNT_BITS-1:0] - prev_right);
  assign sum = {dl[COUNT_BITS-1], dl} + {dr[COUNT_BITS-1], dr};
  assign dif = {dr[COUNT_BITS-1], dr} - {dl[COUNT_BITS-1], dl};

  // Sign and magnitude of the sum and difference terms.
  assign sum_abs = sum[COUNT_BITS] ? $unsigned(-sum) : $unsigned(sum);
  assign dif_abs = dif[COUNT_BITS] ? $unsigned(-dif) : $unsigned(dif);

  always_comb begin
    item.sum_neg       = sum[COUNT_BITS];
    item.sum_mag       = 33'(sum_abs);
    item.dif_neg       = dif[COUNT_BITS];
    item.dif_mag       = 33'(dif_abs);
    item.interval      = req.interval_ms;
    item.interval_zero = (req.interval_ms == 8'sd0);
  end

  assign req.ready = !full;
  assign push      = req.valid && !full;

  // Keep the last counts of every accepted report.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
    end else if (push) begin
      prev_left  <= req.left_count[COUNT_BITS-1:0];
      prev_right <= req.right_count[COUNT_BITS-1:0];
    end
  end

endmodule

>>> rtl/ddo_queue.sv
// Two-entry queue between front and back end.
module ddo_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ddo_pkg::ddo_item_t push_item,
  output logic               full,
  input  logic               pop,
  output ddo_pkg::ddo_item_t pop_item,
  output logic               empty,
  output logic [1:0]         count
);
  import ddo_pkg::*;

  ddo_item_t entries [2];
  logic      wr_ptr;
  logic      rd_ptr;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_item = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

>>> rtl/ddo_div.sv
// Bit-serial restoring divider: wide dividend by an 8-bit divisor.
module ddo_div (
  input  logic              clk,
  input  logic              rst,
  input  ddo_pkg::div_req_t req,
  output ddo_pkg::div_rsp_t rsp
);
  import ddo_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] work;
  logic [7:0]       rem;
  logic [7:0]       dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [8:0]       rem_sh;
  logic             ge;

  // One quotient bit per cycle, most significant first.
  assign rem_sh = {rem, work[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      dsr  <= req.divisor;
      rem  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? 8'(rem_sh - {1'b0, dsr}) : rem_sh[7:0];
      work <= {work[DIV_W-2:0], ge};
      cnt  <= cnt + CNT_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule

>>> rtl/ddo_back.sv
// Back end: scales deltas, runs the CORDIC, updates the pose, forms velocities.
module ddo_back #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         straight_scale,
  input  logic [31:0]         turn_scale,
  input  logic                q_empty,
  input  ddo_pkg::ddo_item_t  q_item,
  output logic                pop,
  output ddo_pkg::div_req_t   div_req,
  input  ddo_pkg::div_rsp_t   div_rsp,
  output ddo_pkg::back_stat_t stat,
  ddo_res_if.source           res
);
  import ddo_pkg::*;

  localparam int N_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  typedef enum logic [17:0] {
    ST_IDLE   = 18'h00001,
    ST_MUL_S  = 18'h00002,
    ST_DIV_S  = 18'h00004,
    ST_WAIT_S = 18'h00008,
    ST_MUL_D  = 18'h00010,
    ST_DTH    = 18'h00020,
    ST_CORD   = 18'h00040,
    ST_TX_LO  = 18'h00080,
    ST_TX_HI  = 18'h00100,
    ST_TX_ADD = 18'h00200,
    ST_TY_LO  = 18'h00400,
    ST_TY_HI  = 18'h00800,
    ST_TY_ADD = 18'h01000,
    ST_VEL_L  = 18'h02000,
    ST_WAIT_L = 18'h04000,
    ST_VEL_A  = 18'h08000,
    ST_WAIT_A = 18'h10000,
    ST_OUT    = 18'h20000
  } state_t;

  state_t state, state_next;

  ddo_item_t          cur;
  logic [63:0]        mul_q;
  logic [61:0]        p_lo;
  logic [DIST_W-1:0]  dist_mag;
  logic [63:0]        dth_mag;
  logic [31:0]        acc_x, acc_y, acc_heading;
  logic signed [33:0] cx, cy, cz;
  logic [5:0]         cnt;
  logic               flip;
  logic [31:0]        lin_v, ang_v;
  logic [31:0]        o_x, o_y, o_h, o_lv, o_av;
  logic               o_iz, out_v;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [64:0]        sfull, dfull;
  logic [31:0]        dth_lo, hd_new, hd_fold;
  logic               fold;
  logic signed [33:0] sx, sy, at, xn, yn, zn;
  logic               cord_last;
  logic [31:0]        cx_mag, cy_mag, c_mag;
  logic [62:0]        lo_rnd;
  logic [31:0]        trig_r, trig_s;
  logic               trig_neg;
  logic [7:0]         adt;
  logic               lin_neg, ang_neg, lin_big, ang_big, out_free;

  logic [55:0]        dq;
  logic [6:0]         drem;
  logic [2:0]         dcnt;
  logic [14:0]        dv;
  logic [30:0]        dv_m;
  logic [7:0]         dqd;
  logic [14:0]        dv_r;
  logic               dist_last;

  // Saturate a velocity quotient given its sign and an overflow flag.
  function automatic logic [31:0] sat_vel(input logic neg, input logic big,
                                          input logic [DIV_W-1:0] q);
    logic over;
    logic [31:0] r;
    over = big || (|q[DIV_W-1:31]);
    if (neg) begin
      r = over ? 32'h8000_0000 : 32'(32'd0 - q[31:0]);
    end else begin
      r = (over || (&q[30:0])) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  // Shared multiplier, operands chosen by the sequencer.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_S: begin
        mul_a = cur.sum_mag[31:0];
        mul_b = straight_scale;
      end
      ST_MUL_D: begin
        mul_a = cur.dif_mag[31:0];
        mul_b = turn_scale;
      end
      ST_TX_LO, ST_TY_LO: begin
        mul_a = {2'b00, dist_mag[29:0]};
        mul_b = c_mag;
      end
      ST_TX_HI, ST_TY_HI: begin
        mul_a = 32'(dist_mag[DIST_W-1:30]);
        mul_b = c_mag;
      end
      ST_VEL_L: begin
        mul_a = dist_mag[31:0];
        mul_b = MS_PER_S;
      end
      ST_VEL_A: begin
        mul_a = dth_mag[31:0];
        mul_b = MS_PER_S;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // Rounded scaled products; a magnitude of exactly 2^32 adds scale << 32.
  assign sfull = {1'b0, mul_q} + (cur.sum_mag[32] ? {1'b0, straight_scale, 32'd0} : 65'd0)
               + DIST_BIAS;
  assign dfull = {1'b0, mul_q} + (cur.dif_mag[32] ? {1'b0, turn_scale, 32'd0} : 65'd0)
               + 65'd1;
  assign dth_lo  = cur.dif_neg ? (32'd0 - dfull[32:1]) : dfull[32:1];
  assign hd_new  = acc_heading + dth_lo;
  assign fold    = hd_new[31] ^ hd_new[30];
  assign hd_fold = fold ? (hd_new ^ 32'h8000_0000) : hd_new;

  // Distance divide by 125, eight quotient bits per cycle by reciprocal multiply.
  assign dv        = {drem, dq[55:48]};
  assign dv_m      = 31'(dv) * 31'(DIST_RECIP);
  assign dqd       = 8'(dv_m >> DIST_RECIP_SH);
  assign dv_r      = dv - 15'(dqd) * 15'(DIST_DIV);
  assign dist_last = (dcnt == 3'd6);

  // One CORDIC rotation step with floor shifts.
  assign sx = cx >>> cnt[4:0];
  assign sy = cy >>> cnt[4:0];
  assign at = $signed({4'd0, ATAN_TAB[cnt[4:0]]});
  always_comb begin
    if (!cz[33]) begin
      xn = cx - sy;
      yn = cy + sx;
      zn = cz - at;
    end else begin
      xn = cx + sy;
      yn = cy - sx;
      zn = cz + at;
    end
  end
  assign cord_last = (cnt == 6'(N_STEPS - 1));

  // Distance times cosine or sine, rounded, low 32 bits.
  assign cx_mag   = cx[33] ? 32'(-cx) : cx[31:0];
  assign cy_mag   = cy[33] ? 32'(-cy) : cy[31:0];
  assign c_mag    = (state == ST_TY_LO || state == ST_TY_HI) ? cy_mag : cx_mag;
  assign lo_rnd   = {1'b0, p_lo} + 63'h2000_0000;
  assign trig_r   = mul_q[31:0] + lo_rnd[61:30];
  assign trig_neg = cur.sum_neg ^ ((state == ST_TY_ADD) ? cy[33] : cx[33]);
  assign trig_s   = trig_neg ? (32'd0 - trig_r) : trig_r;

  // Velocity operands.
  assign adt      = cur.interval[7] ? 8'(-cur.interval) : cur.interval;
  assign lin_neg  = cur.sum_neg ^ cur.interval[7];
  assign ang_neg  = cur.dif_neg ^ cur.interval[7];
  assign lin_big  = |dist_mag[DIST_W-1:32];
  assign ang_big  = |dth_mag[63:32];
  assign out_free = !out_v || res.ready;

  // Divider requests.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = mul_p[DIV_W-1:0];
    div_req.divisor  = adt;
    case (state)
      ST_VEL_L: div_req.start = !cur.interval_zero && !lin_big;
      ST_VEL_A: div_req.start = !cur.interval_zero && !ang_big;
      default:  div_req.start = 1'b0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (!q_empty) state_next = ST_MUL_S;
      ST_MUL_S:  state_next = ST_DIV_S;
      ST_DIV_S:  state_next = ST_WAIT_S;
      ST_WAIT_S: if (dist_last) state_next = ST_MUL_D;
      ST_MUL_D:  state_next = ST_DTH;
      ST_DTH:    state_next = ST_CORD;
      ST_CORD:   if (cord_last) state_next = ST_TX_LO;
      ST_TX_LO:  state_next = ST_TX_HI;
      ST_TX_HI:  state_next = ST_TX_ADD;
      ST_TX_ADD: state_next = ST_TY_LO;
      ST_TY_LO:  state_next = ST_TY_HI;
      ST_TY_HI:  state_next = ST_TY_ADD;
      ST_TY_ADD: state_next = ST_VEL_L;
      ST_VEL_L:  state_next = div_req.start ? ST_WAIT_L : ST_VEL_A;
      ST_WAIT_L: if (div_rsp.done) state_next = ST_VEL_A;
      ST_VEL_A:  state_next = div_req.start ? ST_WAIT_A : ST_OUT;
      ST_WAIT_A: if (div_rsp.done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign pop       = (state == ST_IDLE) && !q_empty;
  assign stat.busy = (state != ST_IDLE);

  // Control state, pose accumulators and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      out_v       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DTH) acc_heading <= hd_new;
      if (state == ST_TX_ADD) acc_x <= acc_x + trig_s;
      if (state == ST_TY_ADD) acc_y <= acc_y + trig_s;
      out_v <= (state == ST_OUT && out_free) || (out_v && !res.ready);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) cur <= q_item;
    mul_q <= mul_p;
    if (state == ST_TX_HI || state == ST_TY_HI) p_lo <= mul_q[61:0];
    if (state == ST_DIV_S) begin
      dq   <= {3'b000, sfull[64:DIST_SHIFT]};
      drem <= '0;
      dcnt <= '0;
    end
    if (state == ST_WAIT_S) begin
      dq   <= {dq[47:0], dqd};
      drem <= dv_r[6:0];
      dcnt <= dcnt + 3'd1;
      if (dist_last) dist_mag <= {dq[37:0], dqd};
    end
    if (state == ST_DTH) begin
      dth_mag <= dfull[64:1];
      cx      <= CORDIC_GAIN;
      cy      <= '0;
      cz      <= $signed({{2{hd_fold[31]}}, hd_fold});
      cnt     <= '0;
      flip    <= fold;
    end
    if (state == ST_CORD) begin
      cx  <= (cord_last && flip) ? -xn : xn;
      cy  <= (cord_last && flip) ? -yn : yn;
      cz  <= zn;
      cnt <= cnt + 6'd1;
    end
    if (state == ST_VEL_L) begin
      if (cur.interval_zero) lin_v <= '0;
      else if (lin_big) lin_v <= sat_vel(lin_neg, 1'b1, '0);
    end
    if (state == ST_WAIT_L && div_rsp.done) lin_v <= sat_vel(lin_neg, 1'b0, div_rsp.quotient);
    if (state == ST_VEL_A) begin
      if (cur.interval_zero) ang_v <= '0;
      else if (ang_big) ang_v <= sat_vel(ang_neg, 1'b1, '0);
    end
    if (state == ST_WAIT_A && div_rsp.done) ang_v <= sat_vel(ang_neg, 1'b0, div_rsp.quotient);
    if (state == ST_OUT && out_free) begin
      o_x  <= acc_x;
      o_y  <= acc_y;
      o_h  <= acc_heading;
      o_lv <= lin_v;
      o_av <= ang_v;
      o_iz <= cur.interval_zero;
    end
  end

  assign res.valid         = out_v;
  assign res.pos_x         = $signed(o_x);
  assign res.pos_y         = $signed(o_y);
  assign res.heading       = $signed(o_h);
  assign res.lin_vel       = $signed(o_lv);
  assign res.ang_vel       = $signed(o_av);
  assign res.interval_zero = o_iz;

endmodule

>>> rtl/diff_drive_odometry.sv
// Differential-drive wheel odometry: top level with configuration registers.
//
// Usage: each transaction on req carries absolute left and right wheel counts
// and the milliseconds since the previous report. For each one, res carries
// one transaction with the updated pose (x, y, heading) and the linear and
// angular velocity. A zero interval forces both velocities to zero and sets
// interval_zero. cfg writes straight_scale (index 0) or turn_scale (index 1);
// it is always ready and should only be written while the block is idle.
// The bit-serial divider, one quotient bit per cycle, serves both velocities
// in turn and is skipped for a zero interval or a saturated velocity; the
// distance scaling divides by a constant eight bits per cycle.
// Reports are worked one at a time: a new one starts only once the last
// result is in the result register.
// A two-entry queue lets up to two reports wait while one is in work, and the
// result register holds a finished result while res is stalled.
// Reset clears the pose, the last counts, the queue and the result valid,
// and restores the scale registers.
`include "assert_macros.svh"
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int COUNT_BITS   = ddo_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ddo_req_if.sink   req,
  ddo_res_if.source res,
  ddo_cfg_if.sink   cfg
);
  import ddo_pkg::*;

  logic [31:0] straight_scale;
  logic [31:0] turn_scale;
  ddo_item_t   f_item, q_item;
  logic        q_push, q_full, q_pop, q_empty;
  logic [1:0]  q_count;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  back_stat_t  bk_stat;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      straight_scale <= STRAIGHT_RESET;
      turn_scale     <= TURN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_STRAIGHT: straight_scale <= cfg.data;
        REG_TURN:     turn_scale     <= cfg.data;
        default:      ;
      endcase
    end
  end

  ddo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .item (f_item),
    .push (q_push),
    .full (q_full)
  );

  ddo_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty),
    .count     (q_count)
  );

  ddo_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ddo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .straight_scale (straight_scale),
    .turn_scale     (turn_scale),
    .q_empty        (q_empty),
    .q_item         (q_item),
    .pop            (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .stat           (bk_stat),
    .res            (res)
  );

  // Queue and sequencer consistency.
  `DDO_ASSERT_ALWAYS(a_q_bound, q_count <= 2'd2, "queue holds more than two entries")
  `DDO_ASSERT_ALWAYS(a_pop_nonempty, !(q_pop && q_empty), "pop from an empty queue")
  `DDO_ASSERT_NEXT(a_pop_busy, q_pop, bk_stat.busy, "back end idle right after a pop")

endmodule
